// ----- hw/rtl/cbd_pkg.sv -----
//------------------------------------------------------------------------------
// cbd_pkg
// Shared types and constants for the capture block deframer.
//------------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	localparam logic [31:0] ALIGN_BYTES = 32'd4;
	localparam logic [31:0] EMPTY_BYTES = 32'd12;
	localparam int ALIGN_SHIFT = $clog2(ALIGN_BYTES);
	localparam int WL_W = 32 - ALIGN_SHIFT;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_LEN,
		PH_BODY,
		PH_TAIL,
		PH_ERR
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_BODY   = 2'd1,
		KIND_DONE   = 2'd2,
		KIND_ERROR  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_BAD_SIZE  = 2'd1,
		ERR_TRUNCATED = 2'd2
	} err_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] block_type;
		logic [31:0] body_length;
		logic [31:0] body_word;
		logic        last_body;
		logic [31:0] block_index;
		err_t        error_code;
	} res_t;

	typedef struct packed {
		logic emit;
		logic in_error;
	} step_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cbd_step.sv -----
//------------------------------------------------------------------------------
// cbd_step
// Block framing state and per-item result logic.
//------------------------------------------------------------------------------
`default_nettype none

module cbd_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [31:0]       data_word,
	input  wire logic              stream_end,
	input  wire logic              pass_body,
	output cbd_pkg::res_t          res,
	output cbd_pkg::step_status_t  status
);

	cbd_pkg::phase_t              phase_q, phase_d;
	logic [31:0]                  held_type_q, held_type_d;
	logic [31:0]                  held_length_q, held_length_d;
	logic [cbd_pkg::WL_W-1:0]     words_left_q, words_left_d;
	logic [31:0]                  blocks_done_q, blocks_done_d;

	logic [31:0]                  word_body_bytes;
	logic [31:0]                  held_body_bytes;
	logic [cbd_pkg::WL_W-1:0]     wl_dec;
	logic                         len_bad;
	logic                         emit;

	assign word_body_bytes = data_word - cbd_pkg::EMPTY_BYTES;
	assign held_body_bytes = held_length_q - cbd_pkg::EMPTY_BYTES;
	assign wl_dec          = words_left_q - {{(cbd_pkg::WL_W-1){1'b0}}, 1'b1};
	assign len_bad         = (data_word[cbd_pkg::ALIGN_SHIFT-1:0] != '0) ||
	                         (data_word < cbd_pkg::EMPTY_BYTES);

	// next state
	always_comb begin
		phase_d       = phase_q;
		held_type_d   = held_type_q;
		held_length_d = held_length_q;
		words_left_d  = words_left_q;
		blocks_done_d = blocks_done_q;
		if (stream_end) begin
			if (phase_q != cbd_pkg::PH_TYPE) begin
				phase_d = cbd_pkg::PH_ERR;
			end
		end else begin
			unique case (phase_q)
				cbd_pkg::PH_TYPE: begin
					held_type_d = data_word;
					phase_d     = cbd_pkg::PH_LEN;
				end
				cbd_pkg::PH_LEN: begin
					if (len_bad) begin
						phase_d = cbd_pkg::PH_ERR;
					end else begin
						held_length_d = data_word;
						words_left_d  = word_body_bytes[31:cbd_pkg::ALIGN_SHIFT];
						phase_d = (word_body_bytes[31:cbd_pkg::ALIGN_SHIFT] != '0) ?
						          cbd_pkg::PH_BODY : cbd_pkg::PH_TAIL;
					end
				end
				cbd_pkg::PH_BODY: begin
					words_left_d = wl_dec;
					if (wl_dec == '0) begin
						phase_d = cbd_pkg::PH_TAIL;
					end
				end
				cbd_pkg::PH_TAIL: begin
					if (data_word != held_length_q) begin
						phase_d = cbd_pkg::PH_ERR;
					end else begin
						blocks_done_d = blocks_done_q + 32'd1;
						phase_d       = cbd_pkg::PH_TYPE;
					end
				end
				default: begin
					phase_d = cbd_pkg::PH_ERR;
				end
			endcase
		end
		if (phase_q == cbd_pkg::PH_ERR) begin
			phase_d       = cbd_pkg::PH_ERR;
			held_type_d   = held_type_q;
			held_length_d = held_length_q;
			words_left_d  = words_left_q;
			blocks_done_d = blocks_done_q;
		end
	end

	// result
	always_comb begin
		emit            = 1'b0;
		res.kind        = cbd_pkg::KIND_ERROR;
		res.block_type  = held_type_q;
		res.body_length = '0;
		res.body_word   = '0;
		res.last_body   = 1'b0;
		res.block_index = blocks_done_q;
		res.error_code  = cbd_pkg::ERR_NONE;
		if (phase_q == cbd_pkg::PH_ERR) begin
			emit = 1'b0;
		end else if (stream_end) begin
			if (phase_q != cbd_pkg::PH_TYPE) begin
				emit           = 1'b1;
				res.error_code = cbd_pkg::ERR_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				cbd_pkg::PH_LEN: begin
					emit = 1'b1;
					if (len_bad) begin
						res.error_code = cbd_pkg::ERR_BAD_SIZE;
					end else begin
						res.kind        = cbd_pkg::KIND_HEADER;
						res.body_length = word_body_bytes;
					end
				end
				cbd_pkg::PH_BODY: begin
					emit            = pass_body;
					res.kind        = cbd_pkg::KIND_BODY;
					res.body_length = held_body_bytes;
					res.body_word   = data_word;
					res.last_body   = (wl_dec == '0);
				end
				cbd_pkg::PH_TAIL: begin
					emit = 1'b1;
					if (data_word != held_length_q) begin
						res.error_code = cbd_pkg::ERR_BAD_SIZE;
					end else begin
						res.kind        = cbd_pkg::KIND_DONE;
						res.body_length = held_body_bytes;
					end
				end
				default: begin
					emit = 1'b0;
				end
			endcase
		end
	end

	assign status.emit     = emit;
	assign status.in_error = (phase_q == cbd_pkg::PH_ERR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= cbd_pkg::PH_TYPE;
			held_type_q   <= '0;
			held_length_q <= '0;
			words_left_q  <= '0;
			blocks_done_q <= '0;
		end else if (fire) begin
			phase_q       <= phase_d;
			held_type_q   <= held_type_d;
			held_length_q <= held_length_d;
			words_left_q  <= words_left_d;
			blocks_done_q <= blocks_done_d;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/capture_block_deframer.sv -----
//------------------------------------------------------------------------------
// capture_block_deframer
// Splits a stream of 32-bit words into capture-file blocks and checks sizes.
//------------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_stall  data_word, stream_end
// out       output     out_valid/out_stall result_kind .. error_code
// cfg       input      cfg_wr_en          cfg_wr_data (pass_body)
//
// one item per cycle sustained while out_stall is low; an accepted item passes
// the input register and then the result register around the framing logic
// reset clears framing state, counter and pass_body (to 1)
// a stalled result holds the result register; the input register still
// takes an item while the result register is being drained
//------------------------------------------------------------------------------
`default_nettype none

module capture_block_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic        cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] data_word,
	input  wire logic        stream_end,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       result_kind,
	output logic [31:0]      block_type,
	output logic [31:0]      body_length,
	output logic [31:0]      body_word,
	output logic             last_body,
	output logic [31:0]      block_index,
	output logic [1:0]       error_code
);

	logic                  pass_body_q;
	logic                  valid_s1;
	logic [31:0]           data_word_s1;
	logic                  stream_end_s1;
	logic                  out_valid_q;
	cbd_pkg::res_t         res_q;
	cbd_pkg::res_t         step_res;
	cbd_pkg::step_status_t step_st;
	logic                  out_free;
	logic                  fire;

	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_body_q <= 1'b1;
		end else if (cfg_wr_en) begin
			pass_body_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_word_s1  <= data_word;
			stream_end_s1 <= stream_end;
		end
	end

	cbd_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.data_word  (data_word_s1),
		.stream_end (stream_end_s1),
		.pass_body  (pass_body_q),
		.res        (step_res),
		.status     (step_st)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && step_st.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && step_st.emit) begin
			res_q <= step_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign result_kind = res_q.kind;
	assign block_type  = res_q.block_type;
	assign body_length = res_q.body_length;
	assign body_word   = res_q.body_word;
	assign last_body   = res_q.last_body;
	assign block_index = res_q.block_index;
	assign error_code  = res_q.error_code;

	a_err_has_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.kind == cbd_pkg::KIND_ERROR) |->
		(res_q.error_code != cbd_pkg::ERR_NONE))
		else $error("error item without error code");

	a_ok_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.kind != cbd_pkg::KIND_ERROR) |->
		(res_q.error_code == cbd_pkg::ERR_NONE))
		else $error("non-error item carries error code");

	a_silent_after_err: assert property (@(posedge clk) disable iff (!arst_n)
		step_st.in_error |-> !(fire && step_st.emit))
		else $error("item produced after sticky error");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled with room downstream");

endmodule

`default_nettype wire

// ----- tb/tb_capture_block_deframer.sv -----
//------------------------------------------------------------------------------
// tb_capture_block_deframer
// Self-checking testbench for the capture block deframer. It feeds words
// with random valid gaps and result stalls, and predicts every result with a
// cycle-free model of the block framing. Each result is checked field by
// field against the oldest prediction. The run starts with directed blocks.
// It then runs the skip-body test, sends random well-formed blocks under both
// body settings and ends with one sticky error case chosen at random.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_capture_block_deframer;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 4;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic        cfg_wr_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] data_word;
	logic        stream_end;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  result_kind;
	logic [31:0] block_type;
	logic [31:0] body_length;
	logic [31:0] body_word;
	logic        last_body;
	logic [31:0] block_index;
	logic [1:0]  error_code;

	capture_block_deframer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_word   (data_word),
		.stream_end  (stream_end),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_kind (result_kind),
		.block_type  (block_type),
		.body_length (body_length),
		.body_word   (body_word),
		.last_body   (last_body),
		.block_index (block_index),
		.error_code  (error_code)
	);

	// framing model state
	cbd_pkg::phase_t          frame_phase;
	logic [31:0]              cur_type;
	logic [31:0]              cur_length;
	logic [cbd_pkg::WL_W-1:0] body_left;
	logic [31:0]              blocks_seen;
	logic                     body_enable;

	cbd_pkg::res_t pending_results[$];
	int   error_count;
	int   items_sent;
	int   burst_left;
	int   cycle_count;

	initial begin
		clk = 1'b0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic add_result(input cbd_pkg::kind_t kind, input logic [31:0] blen,
		input logic [31:0] word, input logic last, input cbd_pkg::err_t code);
		cbd_pkg::res_t r;
		r.kind = kind;
		r.block_type = cur_type;
		r.body_length = blen;
		r.body_word = word;
		r.last_body = last;
		r.block_index = blocks_seen;
		r.error_code = code;
		pending_results.push_back(r);
	endtask

	task automatic raise_error(input cbd_pkg::err_t code);
		frame_phase = cbd_pkg::PH_ERR;
		add_result(cbd_pkg::KIND_ERROR, 32'd0, 32'd0, 1'b0, code);
	endtask

	task automatic deframe_word(input logic [31:0] w, input logic e);
		logic [31:0] words;
		if (frame_phase == cbd_pkg::PH_ERR)
			return;
		if (e) begin
			if (frame_phase != cbd_pkg::PH_TYPE)
				raise_error(cbd_pkg::ERR_TRUNCATED);
			return;
		end
		case (frame_phase)
			cbd_pkg::PH_TYPE: begin
				cur_type = w;
				frame_phase = cbd_pkg::PH_LEN;
			end
			cbd_pkg::PH_LEN: begin
				if ((w % cbd_pkg::ALIGN_BYTES) != 0 || w < cbd_pkg::EMPTY_BYTES) begin
					raise_error(cbd_pkg::ERR_BAD_SIZE);
				end else begin
					cur_length = w;
					words = (w - cbd_pkg::EMPTY_BYTES) >> cbd_pkg::ALIGN_SHIFT;
					body_left = words[cbd_pkg::WL_W-1:0];
					frame_phase = (body_left != 0) ? cbd_pkg::PH_BODY : cbd_pkg::PH_TAIL;
					add_result(cbd_pkg::KIND_HEADER, w - cbd_pkg::EMPTY_BYTES, 32'd0,
						1'b0, cbd_pkg::ERR_NONE);
				end
			end
			cbd_pkg::PH_BODY: begin
				body_left = body_left - 1'b1;
				if (body_left == 0)
					frame_phase = cbd_pkg::PH_TAIL;
				if (body_enable)
					add_result(cbd_pkg::KIND_BODY, cur_length - cbd_pkg::EMPTY_BYTES, w,
						body_left == 0, cbd_pkg::ERR_NONE);
			end
			cbd_pkg::PH_TAIL: begin
				if (w != cur_length) begin
					raise_error(cbd_pkg::ERR_BAD_SIZE);
				end else begin
					add_result(cbd_pkg::KIND_DONE, cur_length - cbd_pkg::EMPTY_BYTES,
						32'd0, 1'b0, cbd_pkg::ERR_NONE);
					blocks_seen = blocks_seen + 1;
					frame_phase = cbd_pkg::PH_TYPE;
				end
			end
			default: begin
				frame_phase = cbd_pkg::PH_ERR;
			end
		endcase
	endtask

	function automatic int next_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(20, 80);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(input logic [31:0] w, input logic e);
		int gap;
		gap = next_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_word <= w;
		stream_end <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		deframe_word(w, e);
	endtask

	task automatic send_block(input logic [31:0] btype, input int nbody,
		input logic with_tail);
		logic [31:0] len;
		len = cbd_pkg::EMPTY_BYTES + nbody * cbd_pkg::ALIGN_BYTES;
		send_word(btype, 1'b0);
		send_word(len, 1'b0);
		for (int i = 0; i < nbody; i++)
			send_word($urandom, 1'b0);
		if (with_tail)
			send_word(len, 1'b0);
	endtask

	task automatic set_pass_body(input logic value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		body_enable = value;
	endtask

	// checker
	always @(posedge clk) begin
		cbd_pkg::res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: kind %0d", result_kind);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (cbd_pkg::kind_t'(result_kind) != want.kind) begin
					$error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
					error_count++;
				end
				if (block_type != want.block_type) begin
					$error("block_type: expected %h, actual %h", want.block_type, block_type);
					error_count++;
				end
				if (body_length != want.body_length) begin
					$error("body_length: expected %h, actual %h", want.body_length,
						body_length);
					error_count++;
				end
				if (body_word != want.body_word) begin
					$error("body_word: expected %h, actual %h", want.body_word, body_word);
					error_count++;
				end
				if (last_body != want.last_body) begin
					$error("last_body: expected %0d, actual %0d", want.last_body, last_body);
					error_count++;
				end
				if (block_index != want.block_index) begin
					$error("block_index: expected %0d, actual %0d", want.block_index,
						block_index);
					error_count++;
				end
				if (cbd_pkg::err_t'(error_code) != want.error_code) begin
					$error("error_code: expected %0d, actual %0d", want.error_code,
						error_code);
					error_count++;
				end
			end
		end
	end

	// result stalls
	initial begin
		int free_len;
		int hold_len;
		out_stall = 1'b0;
		forever begin
			free_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 200)
				: $urandom_range(1, 12);
			hold_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 3);
			@(negedge clk);
			out_stall <= 1'b0;
			repeat (free_len - 1) @(negedge clk);
			@(negedge clk);
			out_stall <= 1'b1;
			repeat (hold_len - 1) @(negedge clk);
		end
	end

	task automatic test_directed_blocks();
		send_block(32'h0000_0000, 0, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'd20, 1'b0);
		send_word(32'h0000_0000, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'd20, 1'b0);
		send_word(32'h0000_0000, 1'b1);
		send_block(32'hA5A5_5A5A, 1, 1'b1);
	endtask

	task automatic test_skip_body();
		set_pass_body(1'b0);
		send_block(32'h5A5A_A5A5, 2, 1'b1);
		send_block(32'h0000_0001, 0, 1'b1);
		send_word($urandom, 1'b1);
	endtask

	task automatic test_random_blocks(input logic pass, input int count);
		int target;
		int r;
		int nbody;
		set_pass_body(pass);
		target = items_sent + count;
		while (items_sent < target) begin
			if ($urandom_range(0, 19) == 0) begin
				send_word($urandom, 1'b1);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					nbody = $urandom_range(0, 4);
				else if (r < 95)
					nbody = $urandom_range(5, 16);
				else
					nbody = $urandom_range(17, 64);
				send_block($urandom, nbody, 1'b1);
			end
		end
	endtask

	// one sticky error closes the run, followed by inputs that must be ignored
	task automatic test_final_error();
		logic [31:0] len;
		int nbody;
		case ($urandom_range(0, 5))
			0: begin
				len = $urandom;
				len[1:0] = $urandom_range(1, 3);
				send_word($urandom, 1'b0);
				send_word(len, 1'b0);
			end
			1: begin
				send_word($urandom, 1'b0);
				send_word($urandom_range(0, 11), 1'b0);
			end
			2: begin
				nbody = $urandom_range(0, 6);
				len = cbd_pkg::EMPTY_BYTES + nbody * cbd_pkg::ALIGN_BYTES;
				send_block($urandom, nbody, 1'b0);
				send_word(len ^ (32'd1 << $urandom_range(0, 31)), 1'b0);
			end
			3: begin
				send_word($urandom, 1'b0);
				send_word($urandom, 1'b1);
			end
			4: begin
				len = $urandom_range(0, 1) ? 32'hFFFF_FFFC
					: {1'b1, 29'($urandom), 2'b00};
				send_word($urandom, 1'b0);
				send_word(len, 1'b0);
				repeat ($urandom_range(0, 5)) send_word($urandom, 1'b0);
				send_word($urandom, 1'b1);
			end
			default: begin
				send_block($urandom, $urandom_range(0, 4), 1'b0);
				send_word($urandom, 1'b1);
			end
		endcase
		repeat (20) send_word($urandom, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		in_valid = 1'b0;
		data_word = 32'd0;
		stream_end = 1'b0;
		error_count = 0;
		items_sent = 0;
		burst_left = 0;
		cycle_count = 0;
		frame_phase = cbd_pkg::PH_TYPE;
		cur_type = 32'd0;
		cur_length = 32'd0;
		body_left = '0;
		blocks_seen = 32'd0;
		body_enable = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_blocks();
		test_skip_body();
		test_random_blocks(1'b1, 400);
		test_random_blocks(1'b0, 400);
		test_random_blocks(1'b1, 400);
		test_random_blocks(1'b0, 200);
		test_random_blocks(1'b1, 220);
		test_final_error();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/cbd_pkg.sv
hw/rtl/cbd_step.sv
hw/rtl/capture_block_deframer.sv
tb/tb_capture_block_deframer.sv
